// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// next-cycle implication, checked through reset as well
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/tmi_pkg.sv =====
// Package: constants, codes, state and control types of the tape machine interpreter
`default_nettype none
package tmi_pkg;

   localparam int PROG_DEPTH = 1024;
   localparam int TAPE_DEPTH = 1024;
   localparam int CELL_WIDTH = 32;

   localparam int PROG_AW = $clog2(PROG_DEPTH);
   localparam int PTR_W   = $clog2(TAPE_DEPTH);

   localparam int OP_W   = 2;
   localparam int ADDR_W = 10;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 11;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;

   localparam logic [BYTE_W-1:0] SYM_INC   = 8'h2B;
   localparam logic [BYTE_W-1:0] SYM_DEC   = 8'h2D;
   localparam logic [BYTE_W-1:0] SYM_RIGHT = 8'h3E;
   localparam logic [BYTE_W-1:0] SYM_LEFT  = 8'h3C;
   localparam logic [BYTE_W-1:0] SYM_INT   = 8'h3A;
   localparam logic [BYTE_W-1:0] SYM_CHR   = 8'h2E;
   localparam logic [BYTE_W-1:0] SYM_OPEN  = 8'h7B;
   localparam logic [BYTE_W-1:0] SYM_CLOSE = 8'h7D;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE   = 2'd0,
      OP_RESTART = 2'd1,
      OP_STEP    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      RUN_ACTIVE   = 2'd0,
      RUN_FINISHED = 2'd1,
      RUN_ERROR    = 2'd2
   } run_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_SCAN_CHK,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic execute;
      logic scan_step;
      logic scan_check;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic step_runs;
      logic scan_start;
      logic scan_end;
      logic scan_hit;
      logic rsp_free;
   } sts_type;

endpackage
`default_nettype wire

// ===== hw/rtl/tmi_req_if.sv =====
// Interface: request channel carrying one input word
`default_nettype none
interface tmi_req_if;
   logic                      valid;
   logic                      ready;
   logic [tmi_pkg::OP_W-1:0]   op;
   logic [tmi_pkg::ADDR_W-1:0] prog_addr;
   logic [tmi_pkg::BYTE_W-1:0] prog_byte;

   modport source (output valid, output op, output prog_addr, output prog_byte, input ready);
   modport sink   (input valid, input op, input prog_addr, input prog_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tmi_rsp_if.sv =====
// Interface: response channel carrying one result word
`default_nettype none
interface tmi_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             out_valid;
   logic                             out_kind;
   logic signed [tmi_pkg::VAL_W-1:0] out_value;
   logic [tmi_pkg::ADDR_W-1:0]       cell_pointer;
   logic [tmi_pkg::LEN_W-1:0]        next_pc;
   logic [tmi_pkg::STAT_W-1:0]       run_status;

   modport source (output valid, output out_valid, output out_kind, output out_value,
                   output cell_pointer, output next_pc, output run_status, input ready);
   modport sink   (input valid, input out_valid, input out_kind, input out_value,
                   input cell_pointer, input next_pc, input run_status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tmi_csr_if.sv =====
// Interface: configuration write channel for the program length register
`default_nettype none
interface tmi_csr_if;
   logic                      valid;
   logic                      ready;
   logic [tmi_pkg::LEN_W-1:0] wdata;

   modport source (output valid, output wdata, input ready);
   modport sink   (input valid, input wdata, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tmi_controller.sv =====
// Controller: sequencing state machine of the tape machine interpreter
`default_nettype none
module tmi_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tmi_pkg::sts_type sts,
   output tmi_pkg::cmd_type cmd
);

   tmi_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmi_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tmi_pkg::ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_last) begin
               state_in = tmi_pkg::ST_IDLE;
            end
         end
         tmi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.step_runs) begin
                  state_in = tmi_pkg::ST_EXEC;
               end else if (sts.rsp_free) begin
                  cmd.load_rsp = 1'b1;
               end else begin
                  state_in = tmi_pkg::ST_HOLD;
               end
            end
         end
         tmi_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
            if (sts.scan_start) begin
               state_in = tmi_pkg::ST_SCAN;
            end else if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = tmi_pkg::ST_IDLE;
            end else begin
               state_in = tmi_pkg::ST_HOLD;
            end
         end
         tmi_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (!sts.scan_end) begin
               state_in = tmi_pkg::ST_SCAN_CHK;
            end else if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = tmi_pkg::ST_IDLE;
            end else begin
               state_in = tmi_pkg::ST_HOLD;
            end
         end
         tmi_pkg::ST_SCAN_CHK: begin
            cmd.scan_check = 1'b1;
            if (!sts.scan_hit) begin
               state_in = tmi_pkg::ST_SCAN;
            end else if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = tmi_pkg::ST_IDLE;
            end else begin
               state_in = tmi_pkg::ST_HOLD;
            end
         end
         tmi_pkg::ST_HOLD: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = tmi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tmi_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/tmi_datapath.sv =====
// Datapath: program and tape memories, machine registers, scan unit and result register
`default_nettype none
module tmi_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  tmi_pkg::cmd_type                 cmd,
   output tmi_pkg::sts_type                 sts,
   input  logic [tmi_pkg::OP_W-1:0]         req_op,
   input  logic [tmi_pkg::ADDR_W-1:0]       req_prog_addr,
   input  logic [tmi_pkg::BYTE_W-1:0]       req_prog_byte,
   input  logic                             csr_valid,
   input  logic [tmi_pkg::LEN_W-1:0]        csr_wdata,
   output logic                             csr_ready,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_out_valid,
   output logic                             rsp_out_kind,
   output logic signed [tmi_pkg::VAL_W-1:0] rsp_out_value,
   output logic [tmi_pkg::ADDR_W-1:0]       rsp_cell_pointer,
   output logic [tmi_pkg::LEN_W-1:0]        rsp_next_pc,
   output logic [tmi_pkg::STAT_W-1:0]       rsp_run_status
);

   localparam int LEN_W  = tmi_pkg::LEN_W;
   localparam int PTR_W  = tmi_pkg::PTR_W;
   localparam int CELL_W = tmi_pkg::CELL_WIDTH;
   localparam int VAL_W  = tmi_pkg::VAL_W;
   localparam int AW     = tmi_pkg::PROG_AW;
   localparam int BW     = tmi_pkg::BYTE_W;

   logic [BW-1:0]     prog_mem [tmi_pkg::PROG_DEPTH];
   logic [CELL_W-1:0] tape_mem [tmi_pkg::TAPE_DEPTH];
   logic [BW-1:0]     prog_rd_ff;
   logic [CELL_W-1:0] tape_rd_ff;

   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic [LEN_W-1:0]       pc_ff, pc_in;
   logic [LEN_W-1:0]       nest_ff, nest_in;
   logic [LEN_W-1:0]       scan_ff, scan_in;
   logic                   fwd_ff, fwd_in;
   tmi_pkg::run_type       status_ff, status_in;
   logic [LEN_W-1:0]       len_ff;
   logic [PTR_W-1:0]       clr_ff;
   logic                   emit_valid_ff, emit_valid_in;
   logic                   emit_kind_ff, emit_kind_in;
   logic [VAL_W-1:0]       emit_value_ff, emit_value_in;

   logic                   rsp_valid_ff;
   logic                   rsp_out_valid_ff;
   logic                   rsp_out_kind_ff;
   logic [VAL_W-1:0]       rsp_out_value_ff;
   logic [PTR_W-1:0]       rsp_ptr_ff;
   logic [LEN_W-1:0]       rsp_pc_ff;
   logic [tmi_pkg::STAT_W-1:0] rsp_status_ff;

   logic [LEN_W-1:0]  run_len;
   logic [LEN_W-1:0]  pc_plus;
   logic [LEN_W-1:0]  scan_inc;
   logic [LEN_W-1:0]  scan_dec;
   logic [LEN_W-1:0]  scan_next;
   logic [BW-1:0]     sym;
   logic              cell_zero;
   logic [BW-1:0]     open_sym;
   logic [BW-1:0]     close_sym;
   logic              prog_we;
   logic [AW-1:0]     prog_ra;
   logic              tape_we;
   logic [PTR_W-1:0]  tape_wa;
   logic [CELL_W-1:0] tape_wd;

   assign run_len   = (len_ff > LEN_W'(tmi_pkg::PROG_DEPTH)) ?
                      LEN_W'(tmi_pkg::PROG_DEPTH) : len_ff;
   assign pc_plus   = pc_ff + LEN_W'(1);
   assign scan_inc  = scan_ff + LEN_W'(1);
   assign scan_dec  = scan_ff - LEN_W'(1);
   assign scan_next = fwd_ff ? scan_inc : scan_dec;
   assign sym       = prog_rd_ff;
   assign cell_zero = (tape_rd_ff == '0);
   assign open_sym  = fwd_ff ? tmi_pkg::SYM_OPEN : tmi_pkg::SYM_CLOSE;
   assign close_sym = fwd_ff ? tmi_pkg::SYM_CLOSE : tmi_pkg::SYM_OPEN;

   assign prog_we = cmd.accept && (req_op == tmi_pkg::OP_WRITE);
   assign prog_ra = cmd.scan_step ? scan_next[AW-1:0] : pc_ff[AW-1:0];

   assign tape_we = cmd.clear_en ||
                    (cmd.execute && ((sym == tmi_pkg::SYM_INC) || (sym == tmi_pkg::SYM_DEC)));
   assign tape_wa = cmd.clear_en ? clr_ff : ptr_ff;
   assign tape_wd = cmd.clear_en ? '0 :
                    (sym == tmi_pkg::SYM_INC) ? tape_rd_ff + CELL_W'(1) :
                                                tape_rd_ff - CELL_W'(1);

   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem[req_prog_addr[AW-1:0]] <= req_prog_byte;
      end
      prog_rd_ff <= prog_mem[prog_ra];
   end

   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem[tape_wa] <= tape_wd;
      end
      tape_rd_ff <= tape_mem[ptr_ff];
   end

   always_comb begin
      sts.clear_last = (clr_ff == PTR_W'(tmi_pkg::TAPE_DEPTH - 1));
      sts.step_runs  = (req_op == tmi_pkg::OP_STEP) && (status_ff == tmi_pkg::RUN_ACTIVE) &&
                       (pc_ff < run_len);
      sts.scan_start = ((sym == tmi_pkg::SYM_OPEN) && cell_zero) ||
                       ((sym == tmi_pkg::SYM_CLOSE) && !cell_zero);
      sts.scan_end   = fwd_ff ? (scan_inc >= run_len) : (scan_ff == '0);
      sts.scan_hit   = (prog_rd_ff == close_sym) && (nest_ff == '0);
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      ptr_in        = ptr_ff;
      pc_in         = pc_ff;
      nest_in       = nest_ff;
      scan_in       = scan_ff;
      fwd_in        = fwd_ff;
      status_in     = status_ff;
      emit_valid_in = emit_valid_ff;
      emit_kind_in  = emit_kind_ff;
      emit_value_in = emit_value_ff;

      if (cmd.accept) begin
         emit_valid_in = 1'b0;
         emit_kind_in  = 1'b0;
         emit_value_in = '0;
         if (req_op == tmi_pkg::OP_RESTART) begin
            pc_in     = '0;
            nest_in   = '0;
            status_in = tmi_pkg::RUN_ACTIVE;
         end else if ((req_op == tmi_pkg::OP_STEP) && (status_ff == tmi_pkg::RUN_ACTIVE) &&
                      (pc_ff >= run_len)) begin
            status_in = tmi_pkg::RUN_FINISHED;
         end
      end

      if (cmd.execute) begin
         unique case (sym)
            tmi_pkg::SYM_RIGHT: begin
               if (ptr_ff != PTR_W'(tmi_pkg::TAPE_DEPTH - 1)) begin
                  ptr_in = ptr_ff + PTR_W'(1);
               end
            end
            tmi_pkg::SYM_LEFT: begin
               if (ptr_ff != '0) begin
                  ptr_in = ptr_ff - PTR_W'(1);
               end
            end
            tmi_pkg::SYM_INT, tmi_pkg::SYM_CHR: begin
               emit_valid_in = 1'b1;
               emit_kind_in  = (sym == tmi_pkg::SYM_CHR);
               emit_value_in = VAL_W'(signed'(tape_rd_ff));
            end
            default: begin
            end
         endcase
         if (sts.scan_start) begin
            scan_in = pc_ff;
            nest_in = '0;
            fwd_in  = (sym == tmi_pkg::SYM_OPEN);
         end else begin
            pc_in = pc_plus;
            if (pc_plus >= run_len) begin
               status_in = tmi_pkg::RUN_FINISHED;
            end
         end
      end

      if (cmd.scan_step) begin
         if (sts.scan_end) begin
            status_in = tmi_pkg::RUN_ERROR;
            nest_in   = '0;
         end else begin
            scan_in = scan_next;
         end
      end

      if (cmd.scan_check) begin
         if (sts.scan_hit) begin
            pc_in   = scan_inc;
            nest_in = '0;
            if (scan_inc >= run_len) begin
               status_in = tmi_pkg::RUN_FINISHED;
            end
         end else if (prog_rd_ff == open_sym) begin
            nest_in = nest_ff + LEN_W'(1);
         end else if (prog_rd_ff == close_sym) begin
            nest_in = nest_ff - LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         pc_ff     <= '0;
         nest_ff   <= '0;
         status_ff <= tmi_pkg::RUN_ACTIVE;
         len_ff    <= '0;
         clr_ff    <= '0;
      end else begin
         ptr_ff    <= ptr_in;
         pc_ff     <= pc_in;
         nest_ff   <= nest_in;
         status_ff <= status_in;
         if (csr_valid) begin
            len_ff <= csr_wdata;
         end
         if (cmd.clear_en) begin
            clr_ff <= clr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      fwd_ff        <= fwd_in;
      emit_valid_ff <= emit_valid_in;
      emit_kind_ff  <= emit_kind_in;
      emit_value_ff <= emit_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_out_valid_ff <= emit_valid_in;
         rsp_out_kind_ff  <= emit_kind_in;
         rsp_out_value_ff <= emit_value_in;
         rsp_ptr_ff       <= ptr_in;
         rsp_pc_ff        <= pc_in;
         rsp_status_ff    <= status_in;
      end
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_valid    = rsp_out_valid_ff;
   assign rsp_out_kind     = rsp_out_kind_ff;
   assign rsp_out_value    = rsp_out_value_ff;
   assign rsp_cell_pointer = tmi_pkg::ADDR_W'(rsp_ptr_ff);
   assign rsp_next_pc      = rsp_pc_ff;
   assign rsp_run_status   = rsp_status_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/tape_machine_interpreter.sv =====
// Top level: tape machine interpreter, controller and datapath
//
//   channel   direction   word
//   req_ch    in          op, prog_addr, prog_byte
//   rsp_ch    out         out_valid, out_kind, out_value, cell_pointer, next_pc, run_status
//   csr_ch    in          program_length
//
// Program write, restart, unused op and halted or finished step: answered straight from idle.
// Plain symbol: accept registers the program and tape reads, then execute writes the tape.
// Brace jump: execute, then scan and scan-check per byte scanned; no match ends in an error.
// After reset the tape is zeroed one cell a cycle; req_ch is not ready until all 1024 are clear.
// A result held on rsp_ch lets one further word in; it then waits for the result slot.
`default_nettype none
module tape_machine_interpreter (
   input  logic      clock,
   input  logic      reset,
   tmi_req_if.sink   req_ch,
   tmi_rsp_if.source rsp_ch,
   tmi_csr_if.sink   csr_ch
);

   tmi_pkg::cmd_type cmd;
   tmi_pkg::sts_type sts;

   tmi_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tmi_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_op           (req_ch.op),
      .req_prog_addr    (req_ch.prog_addr),
      .req_prog_byte    (req_ch.prog_byte),
      .csr_valid        (csr_ch.valid),
      .csr_wdata        (csr_ch.wdata),
      .csr_ready        (csr_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_out_valid    (rsp_ch.out_valid),
      .rsp_out_kind     (rsp_ch.out_kind),
      .rsp_out_value    (rsp_ch.out_value),
      .rsp_cell_pointer (rsp_ch.cell_pointer),
      .rsp_next_pc      (rsp_ch.next_pc),
      .rsp_run_status   (rsp_ch.run_status)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/tmi_checker.sv =====
// Checker: port-level assertions of the tape machine interpreter, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module tmi_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_out_valid,
   input logic                             rsp_out_kind,
   input logic signed [tmi_pkg::VAL_W-1:0] rsp_out_value,
   input logic [tmi_pkg::LEN_W-1:0]        rsp_next_pc,
   input logic [tmi_pkg::STAT_W-1:0]       rsp_run_status
);

   localparam int LEN_W = tmi_pkg::LEN_W;
   localparam logic [LEN_W-1:0] PC_END = LEN_W'(tmi_pkg::PROG_DEPTH);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_IMPLIES(a_no_emit_clean, clock, reset, rsp_valid && !rsp_out_valid, !rsp_out_kind && (rsp_out_value == '0))
   `ASSERT_IMPLIES(a_status_code, clock, reset, rsp_valid, rsp_run_status <= tmi_pkg::RUN_ERROR)
   `ASSERT_IMPLIES(a_pc_range, clock, reset, rsp_valid && (rsp_run_status == tmi_pkg::RUN_ACTIVE), rsp_next_pc < PC_END)
   `ASSERT_NEXT_ALWAYS(a_clear_blocks, clock, reset, !req_ready)

endmodule

bind tape_machine_interpreter tmi_checker u_tmi_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_out_valid  (rsp_ch.out_valid),
   .rsp_out_kind   (rsp_ch.out_kind),
   .rsp_out_value  (rsp_ch.out_value),
   .rsp_next_pc    (rsp_ch.next_pc),
   .rsp_run_status (rsp_ch.run_status)
);
`default_nettype wire
